### rtl/repeat_play_interval_timer_top_assert.svh
// Assertion macros for the repeat/play interval timer.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef REPEAT_PLAY_INTERVAL_TIMER_TOP_ASSERT_SVH
`define REPEAT_PLAY_INTERVAL_TIMER_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RPIT_ASSERT_HOLD(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define RPIT_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

### rtl/rpit_pkg.sv
// Shared types and constants of the repeat/play interval timer.
// No dependencies; used by the channel interfaces and the top level.
package rpit_pkg;

  localparam int DELTA_W    = 24;
  localparam int PLAYS_W    = 16;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;

  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_START = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ON_TIME      = 2'd0,
    REG_OFF_TIME     = 2'd1,
    REG_REPEAT_COUNT = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_APPLY,
    ST_FIN
  } state_t;

endpackage

### rtl/rpit_if.sv
// Valid/ready channel interfaces of the repeat/play interval timer.
// Depends on rpit_pkg for the payload widths.
interface rpit_in_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [rpit_pkg::DELTA_W-1:0] delta;

  modport source (output valid, output func, output delta, input ready);
  modport sink   (input valid, input func, input delta, output ready);
endinterface

interface rpit_out_if;
  logic                         valid;
  logic                         ready;
  logic                         active;
  logic                         playing;
  logic [rpit_pkg::PLAYS_W-1:0] plays_done;

  modport source (output valid, output active, output playing, output plays_done, input ready);
  modport sink   (input valid, input active, input playing, input plays_done, output ready);
endinterface

### rtl/repeat_play_interval_timer_top.sv
// Repeating on/off burst timer. The input channel carries transactions with func and delta:
// func = start loads a burst from on_time, off_time and repeat_count; func = tick adds delta
// to the running phase timer. Every input transaction yields exactly one result transaction
// (active, playing, plays_done) on the output channel. Write the registers on the cfg_ port only
// while no transaction is in flight; the block itself does not enforce this.
// Steps per transaction, from acceptance until in_ch.ready rises again:
//   start: ST_MUL (one repeat-count bit per cycle in the shift-add multiplier), ST_LOAD, ST_FIN
//   tick that stays inside the current phase, any tick while idle, or a tick while on_time
//   and off_time are both zero: ST_FIN
//   tick that crosses a phase end: ST_DIV (one quotient bit per cycle in the restoring
//   divider by the period), ST_APPLY, ST_FIN; the divider pre-shifts a narrow dividend, but
//   takes the full dividend when the phase timer has grown past TIME_BITS + 1 bits, which
//   only happens while the period is zero
// The result is presented in the cycle after the last step. The output register holds one
// result, so the next transaction is accepted while that result still waits; when the receiver
// stalls, the block finishes the next transaction and then waits in its final step until the output register is free.
// Reset (rst_n low, synchronous) clears the registers, the burst state and the output valid.
`include "repeat_play_interval_timer_top_assert.svh"

module repeat_play_interval_timer_top #(
  parameter int TIME_BITS  = 24,
  parameter int COUNT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rpit_in_if.sink                         in_ch,
  rpit_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [rpit_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [((TIME_BITS > COUNT_BITS) ? TIME_BITS : COUNT_BITS)-1:0] cfg_wdata
);

  localparam int T      = TIME_BITS;
  localparam int C      = COUNT_BITS;
  localparam int CFG_W  = (T > C) ? T : C;
  localparam int LEN_W  = T + C + 1;
  localparam int EL_W   = LEN_W + 1;
  localparam int PH_W   = T + 1;
  localparam int DV_W   = LEN_W + 1;
  localparam int REM_W  = T + 2;
  localparam int XW     = (CFG_W > rpit_pkg::DELTA_W) ? CFG_W : rpit_pkg::DELTA_W;
  localparam int PW     = (C > rpit_pkg::PLAYS_W) ? C : rpit_pkg::PLAYS_W;
  localparam int STEPS  = (C > DV_W) ? C : DV_W;
  localparam int SUM_W  = STEPS + 2;
  localparam int STEP_W = $clog2(STEPS + 1);

  rpit_pkg::state_t state_r, state_nxt;

  logic [T-1:0]      on_r, off_r;
  logic [C-1:0]      rep_r;
  logic              active_r, active_nxt;
  logic              playing_r, playing_nxt;
  logic [LEN_W-1:0]  total_r, total_nxt;
  logic [LEN_W-1:0]  elapsed_r, elapsed_nxt;
  logic [LEN_W-1:0]  play_r, play_nxt;
  logic [LEN_W-1:0]  pause_r, pause_nxt;
  logic [C-1:0]      cnt_r, cnt_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  logic [PH_W-1:0]   per_r, per_nxt;
  logic [LEN_W-1:0]  acc_r, acc_nxt;
  logic [C-1:0]      mul_r, mul_nxt;
  logic [DV_W-1:0]   dvd_r, dvd_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic                         out_active_r, out_active_nxt;
  logic                         out_playing_r, out_playing_nxt;
  logic [rpit_pkg::PLAYS_W-1:0] out_plays_r, out_plays_nxt;

  logic [XW-1:0]     cfg_wide, delta_wide;
  logic [T-1:0]      delta_t;
  logic [PH_W-1:0]   on_ext, off_ext;
  logic [DV_W-1:0]   ph_sum, ph_thr;
  logic              per_zero;
  logic [EL_W-1:0]   el_sum;
  logic [LEN_W-1:0]  el_sat;
  logic [LEN_W-1:0]  acc_step, total_calc;
  logic [REM_W-1:0]  rem_sh, rem_sub;
  logic              rem_ge;
  logic [PH_W-1:0]   quo_rem;
  logic              ge;
  logic [SUM_W-1:0]  cnt_sum;
  logic [C-1:0]      cnt_sat;
  logic              act_fin;
  logic [PW-1:0]     plays_wide;

  // Registers and delta are masked or zero-extended to the configured widths.
  assign cfg_wide   = XW'(cfg_wdata);
  assign delta_wide = XW'(in_ch.delta);
  assign delta_t    = delta_wide[T-1:0];
  assign on_ext     = {1'b0, on_r};
  assign off_ext    = {1'b0, off_r};

  // A phase timer never exceeds the elapsed time of the burst, so it fits in LEN_W bits
  // while the burst runs; it only grows past PH_W bits while the period is zero.
  assign ph_sum   = DV_W'(playing_r ? play_r : pause_r) + DV_W'(delta_t);
  assign ph_thr   = DV_W'(playing_r ? on_r : off_r);
  assign per_zero = (on_r == '0) && (off_r == '0);

  assign el_sum = {1'b0, elapsed_r} + EL_W'(delta_t);
  assign el_sat = el_sum[LEN_W] ? {LEN_W{1'b1}} : el_sum[LEN_W-1:0];

  // Shift-add multiply of the period by the repeat count, most significant bit first.
  assign acc_step   = {acc_r[LEN_W-2:0], 1'b0} + (mul_r[C-1] ? LEN_W'(per_r) : '0);
  // R * (on + off) - off equals R * on + (R - 1) * off and never saturates.
  assign total_calc = (rep_r == '0) ? '0 : (acc_r - LEN_W'(off_r));

  // Restoring division: one quotient bit per cycle enters the low end of dvd_r.
  assign rem_sh  = {rem_r[REM_W-2:0], dvd_r[DV_W-1]};
  assign rem_ge  = (rem_sh >= REM_W'(per_r));
  assign rem_sub = rem_ge ? (rem_sh - REM_W'(per_r)) : rem_sh;

  assign quo_rem = rem_r[PH_W-1:0];
  assign ge      = playing_r ? (quo_rem >= on_ext) : (quo_rem >= off_ext);
  // A play phase that ends inside the remainder counts one more play.
  assign cnt_sum = SUM_W'(cnt_r) + SUM_W'(dvd_r) + SUM_W'(playing_r & ge);
  assign cnt_sat = (cnt_sum > SUM_W'({C{1'b1}})) ? {C{1'b1}} : cnt_sum[C-1:0];

  assign act_fin    = active_r & ~(elapsed_r >= total_r);
  assign plays_wide = PW'(cnt_r);

  assign in_ch.ready       = (state_r == rpit_pkg::ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.active     = out_active_r;
  assign out_ch.playing    = out_playing_r;
  assign out_ch.plays_done = out_plays_r;

  always_comb begin
    state_nxt       = state_r;
    active_nxt      = active_r;
    playing_nxt     = playing_r;
    total_nxt       = total_r;
    elapsed_nxt     = elapsed_r;
    play_nxt        = play_r;
    pause_nxt       = pause_r;
    cnt_nxt         = cnt_r;
    step_nxt        = step_r;
    per_nxt         = per_r;
    acc_nxt         = acc_r;
    mul_nxt         = mul_r;
    dvd_nxt         = dvd_r;
    rem_nxt         = rem_r;
    out_valid_nxt   = out_valid_r & ~out_ch.ready;
    out_active_nxt  = out_active_r;
    out_playing_nxt = out_playing_r;
    out_plays_nxt   = out_plays_r;

    unique case (state_r)
      rpit_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          per_nxt = on_ext + off_ext;
          if (in_ch.func == rpit_pkg::FUNC_START) begin
            acc_nxt   = '0;
            mul_nxt   = rep_r;
            step_nxt  = STEP_W'(C);
            state_nxt = rpit_pkg::ST_MUL;
          end else if (active_r) begin
            elapsed_nxt = el_sat;
            // With a zero period the phase timer only accumulates.
            if (!per_zero && (ph_sum >= ph_thr)) begin
              // A narrow dividend is pre-shifted so that only PH_W quotient bits are formed.
              if (ph_sum[DV_W-1:PH_W] == '0) begin
                dvd_nxt  = ph_sum << (DV_W - PH_W);
                step_nxt = STEP_W'(PH_W);
              end else begin
                dvd_nxt  = ph_sum;
                step_nxt = STEP_W'(DV_W);
              end
              rem_nxt   = '0;
              state_nxt = rpit_pkg::ST_DIV;
            end else begin
              if (playing_r) begin
                play_nxt = ph_sum[LEN_W-1:0];
              end else begin
                pause_nxt = ph_sum[LEN_W-1:0];
              end
              state_nxt = rpit_pkg::ST_FIN;
            end
          end else begin
            state_nxt = rpit_pkg::ST_FIN;
          end
        end
      end
      rpit_pkg::ST_MUL: begin
        acc_nxt  = acc_step;
        mul_nxt  = {mul_r[C-2:0], 1'b0};
        step_nxt = step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          state_nxt = rpit_pkg::ST_LOAD;
        end
      end
      rpit_pkg::ST_LOAD: begin
        total_nxt   = total_calc;
        active_nxt  = |total_calc;
        playing_nxt = (|total_calc) & (|on_r);
        elapsed_nxt = '0;
        play_nxt    = '0;
        pause_nxt   = '0;
        cnt_nxt     = '0;
        state_nxt   = rpit_pkg::ST_FIN;
      end
      rpit_pkg::ST_DIV: begin
        rem_nxt  = rem_sub;
        dvd_nxt  = {dvd_r[DV_W-2:0], rem_ge};
        step_nxt = step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          state_nxt = rpit_pkg::ST_APPLY;
        end
      end
      rpit_pkg::ST_APPLY: begin
        cnt_nxt = cnt_sat;
        if (playing_r) begin
          if (ge) begin
            pause_nxt   = LEN_W'(quo_rem - on_ext);
            play_nxt    = '0;
            playing_nxt = 1'b0;
          end else begin
            play_nxt = LEN_W'(quo_rem);
          end
        end else begin
          if (ge) begin
            play_nxt    = LEN_W'(quo_rem - off_ext);
            pause_nxt   = '0;
            playing_nxt = 1'b1;
          end else begin
            pause_nxt = LEN_W'(quo_rem);
          end
        end
        state_nxt = rpit_pkg::ST_FIN;
      end
      rpit_pkg::ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          active_nxt      = act_fin;
          out_valid_nxt   = 1'b1;
          out_active_nxt  = act_fin;
          out_playing_nxt = act_fin & playing_r;
          out_plays_nxt   = plays_wide[rpit_pkg::PLAYS_W-1:0];
          state_nxt       = rpit_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rpit_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rpit_pkg::ST_IDLE;
      step_r      <= '0;
      on_r        <= '0;
      off_r       <= '0;
      rep_r       <= '0;
      active_r    <= 1'b0;
      playing_r   <= 1'b0;
      total_r     <= '0;
      elapsed_r   <= '0;
      play_r      <= '0;
      pause_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      active_r    <= active_nxt;
      playing_r   <= playing_nxt;
      total_r     <= total_nxt;
      elapsed_r   <= elapsed_nxt;
      play_r      <= play_nxt;
      pause_r     <= pause_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          rpit_pkg::REG_ON_TIME:      on_r  <= cfg_wide[T-1:0];
          rpit_pkg::REG_OFF_TIME:     off_r <= cfg_wide[T-1:0];
          rpit_pkg::REG_REPEAT_COUNT: rep_r <= cfg_wide[C-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    per_r         <= per_nxt;
    acc_r         <= acc_nxt;
    mul_r         <= mul_nxt;
    dvd_r         <= dvd_nxt;
    rem_r         <= rem_nxt;
    out_active_r  <= out_active_nxt;
    out_playing_r <= out_playing_nxt;
    out_plays_r   <= out_plays_nxt;
  end

  `RPIT_ASSERT_HOLD(a_elapsed_below_total, (state_r == rpit_pkg::ST_IDLE) && active_r, elapsed_r < total_r, "burst active after its length")
  `RPIT_ASSERT_NEXT(a_accept_leaves_idle, in_ch.valid && in_ch.ready, state_r != rpit_pkg::ST_IDLE, "accepted transaction not started")
  `RPIT_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_plays_r), "stalled result changed")
  `RPIT_ASSERT_HOLD(a_out_playing_active, out_ch.valid, out_ch.active || !out_ch.playing, "playing without active")

endmodule
